/* sv/fenced_first_fit_allocator_core_macros.svh */
// Assertion helpers for the allocator
`ifndef FENCED_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FENCED_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/ffa_pkg.sv */
package ffa_pkg;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_PENDFULL = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RET    = 9'b000000010,
    S_FLUSH  = 9'b000000100,
    S_SORT   = 9'b000001000,
    S_MERGE  = 9'b000010000,
    S_FIT    = 9'b000100000,
    S_SHIFT  = 9'b001000000,
    S_BUMP   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic ret_step;
    logic flush_step;
    logic sort_step;
    logic merge_step;
    logic fit_step;
    logic shift_step;
    logic bump_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic ret_done;
    logic flush_done;
    logic sort_done;
    logic merge_done;
    logic fit_done;
    logic fit_hit;
    logic shift_done;
  } stat_t;
endpackage

/* sv/ffa_ctrl.sv */
module ffa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_mode,
  input  ffa_pkg::stat_t st,
  output ffa_pkg::ctrl_t cmd,
  output logic           busy
);
  ffa_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = in_mode ? ffa_pkg::S_RET : ffa_pkg::S_FLUSH;
        end
      end
      ffa_pkg::S_RET: begin
        cmd.ret_step = 1'b1;
        if (st.ret_done) state_nxt = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_FLUSH: begin
        cmd.flush_step = 1'b1;
        if (st.flush_done) state_nxt = ffa_pkg::S_SORT;
      end
      ffa_pkg::S_SORT: begin
        cmd.sort_step = 1'b1;
        if (st.sort_done) state_nxt = ffa_pkg::S_MERGE;
      end
      ffa_pkg::S_MERGE: begin
        cmd.merge_step = 1'b1;
        if (st.merge_done) state_nxt = ffa_pkg::S_FIT;
      end
      ffa_pkg::S_FIT: begin
        cmd.fit_step = 1'b1;
        if (st.fit_hit) state_nxt = ffa_pkg::S_SHIFT;
        else if (st.fit_done) state_nxt = ffa_pkg::S_BUMP;
      end
      ffa_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_done) state_nxt = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_BUMP: begin
        cmd.bump_step = 1'b1;
        state_nxt = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = ffa_pkg::S_IDLE;
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ffa_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != ffa_pkg::S_IDLE);

  `include "fenced_first_fit_allocator_core_macros.svh"
  `FFA_ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `FFA_ASSERT_NEXT(a_done_idle, clk, rst_n, state_r == ffa_pkg::S_DONE,
    state_r == ffa_pkg::S_IDLE, "done not followed by idle")
  `FFA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
endmodule

/* sv/ffa_dp.sv */
module ffa_dp #(
  parameter int FE = 16,
  parameter int PE = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ffa_pkg::ctrl_t cmd,
  input  logic [31:0]    capacity,
  input  logic [31:0]    in_req_size,
  input  logic [3:0]     in_align_log2,
  input  logic [31:0]    in_ret_offset,
  input  logic [63:0]    in_fence_value,
  input  logic [63:0]    in_completed_fence,
  output ffa_pkg::stat_t st,
  output logic [1:0]     status,
  output logic [31:0]    alloc_offset,
  output logic [31:0]    alloc_size
);
  localparam int FW = $clog2(FE);
  localparam int CW = $clog2(FE + 1);
  localparam int PW = $clog2(PE);
  localparam int QW = $clog2(PE + 1);

  logic [31:0] fo_r [FE];
  logic [31:0] fs_r [FE];
  logic [CW-1:0] fcnt_r;
  logic [63:0] pf_r [PE];
  logic [31:0] po_r [PE];
  logic [31:0] ps_r [PE];
  logic [PE-1:0] pv_r;
  logic [32:0] bump_r;

  logic [31:0] size_r, roff_r;
  logic [63:0] fence_r, done_r;
  logic [32:0] need_r;
  logic [QW-1:0] pi_r;
  logic [CW-1:0] i_r, j_r;
  logic [1:0]  status_r;
  logic [31:0] goff_r, gsize_r;

  logic [32:0] amask, need_c;
  always_comb begin
    amask = (33'd1 << in_align_log2) - 33'd1;
    need_c = ({1'b0, in_req_size} + amask) & ~amask;
  end

  logic [PW-1:0] pidx;
  assign pidx = pi_r[PW-1:0];
  logic [FW-1:0] ix, jx, jm1, ip1;
  assign ix  = i_r[FW-1:0];
  assign jx  = j_r[FW-1:0];
  assign jm1 = FW'(j_r - CW'(1));
  assign ip1 = FW'(i_r + CW'(1));

  logic [32:0] m_end, m_sum;
  assign m_end = {1'b0, fo_r[ix]} + {1'b0, fs_r[ix]};
  assign m_sum = {1'b0, fs_r[ix]} + {1'b0, fs_r[ip1]};
  logic need_ok;
  assign need_ok = (need_r != 33'd0) && !need_r[32];

  // sort: insertion with j walking down; swap j-1 and j while out of order
  logic sort_swap;
  assign sort_swap = (j_r != '0) && (fo_r[jm1] > fo_r[jx]);

  always_comb begin
    st = '0;
    st.ret_done   = 1'b1;
    st.flush_done = (pi_r == QW'(PE));
    st.sort_done  = (i_r >= fcnt_r);
    st.merge_done = (CW'(i_r + CW'(1)) >= fcnt_r);
    st.fit_done   = !need_ok || (i_r >= fcnt_r);
    st.fit_hit    = need_ok && (i_r < fcnt_r) && ({1'b0, fs_r[ix]} >= need_r);
    st.shift_done = (CW'(j_r + CW'(1)) >= fcnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
      pv_r <= '0;
      bump_r <= '0;
    end else begin
      if (cmd.load) begin
        size_r <= in_req_size;
        roff_r <= in_ret_offset;
        fence_r <= in_fence_value;
        done_r <= in_completed_fence;
        need_r <= need_c;
        pi_r <= '0;
        i_r <= CW'(1);
        j_r <= CW'(1);
        status_r <= ffa_pkg::ST_OK;
        goff_r <= '0;
        gsize_r <= '0;
      end
      if (cmd.ret_step && size_r != 32'd0) begin : find_free
        logic hit;
        logic [PW-1:0] sel;
        hit = 1'b0;
        sel = '0;
        for (int p = PE - 1; p >= 0; p--) begin
          if (!pv_r[p]) begin
            hit = 1'b1;
            sel = PW'(p);
          end
        end
        if (hit) begin
          pv_r[sel] <= 1'b1;
          pf_r[sel] <= fence_r;
          po_r[sel] <= roff_r;
          ps_r[sel] <= size_r;
        end else begin
          status_r <= ffa_pkg::ST_PENDFULL;
        end
      end
      if (cmd.flush_step && pi_r != QW'(PE)) begin
        pi_r <= QW'(pi_r + QW'(1));
        if (pv_r[pidx] && pf_r[pidx] <= done_r && fcnt_r < CW'(FE)) begin
          fo_r[fcnt_r[FW-1:0]] <= po_r[pidx];
          fs_r[fcnt_r[FW-1:0]] <= ps_r[pidx];
          fcnt_r <= CW'(fcnt_r + CW'(1));
          pv_r[pidx] <= 1'b0;
        end
      end
      if (cmd.sort_step && i_r < fcnt_r) begin
        if (sort_swap) begin
          fo_r[jm1] <= fo_r[jx];
          fs_r[jm1] <= fs_r[jx];
          fo_r[jx] <= fo_r[jm1];
          fs_r[jx] <= fs_r[jm1];
          j_r <= CW'(j_r - CW'(1));
        end else begin
          i_r <= CW'(i_r + CW'(1));
          j_r <= CW'(i_r + CW'(1));
        end
      end
      if (cmd.sort_step && i_r >= fcnt_r) i_r <= '0;
      if (cmd.merge_step && CW'(i_r + CW'(1)) < fcnt_r) begin
        if (m_end == {1'b0, fo_r[ip1]} && !m_sum[32]) begin
          fs_r[ix] <= m_sum[31:0];
          for (int k = 0; k < FE - 1; k++) begin
            if (k > int'(i_r) && k + 1 < int'(fcnt_r)) begin
              fo_r[k] <= fo_r[k + 1];
              fs_r[k] <= fs_r[k + 1];
            end
          end
          fcnt_r <= CW'(fcnt_r - CW'(1));
        end else begin
          i_r <= CW'(i_r + CW'(1));
        end
      end
      if (cmd.merge_step && CW'(i_r + CW'(1)) >= fcnt_r) i_r <= '0;
      if (cmd.fit_step) begin
        if (st.fit_hit) begin
          goff_r <= fo_r[ix];
          gsize_r <= need_r[31:0];
          if ({1'b0, fs_r[ix]} != need_r) begin
            fs_r[ix] <= fs_r[ix] - need_r[31:0];
            fo_r[ix] <= fo_r[ix] + need_r[31:0];
            j_r <= fcnt_r;
          end else begin
            j_r <= i_r;
          end
        end else if (!st.fit_done) begin
          i_r <= CW'(i_r + CW'(1));
        end
      end
      // remove the exact-fit entry one slot per cycle
      if (cmd.shift_step) begin
        if (CW'(j_r + CW'(1)) < fcnt_r) begin
          fo_r[jx] <= fo_r[FW'(j_r + CW'(1))];
          fs_r[jx] <= fs_r[FW'(j_r + CW'(1))];
          j_r <= CW'(j_r + CW'(1));
        end else if (j_r < fcnt_r) begin
          fcnt_r <= CW'(fcnt_r - CW'(1));
        end
      end
      if (cmd.bump_step) begin
        if (need_ok && ({1'b0, bump_r} + {1'b0, need_r}) <= {2'b0, capacity}) begin
          goff_r <= bump_r[31:0];
          gsize_r <= need_r[31:0];
          bump_r <= 33'(bump_r + need_r);
        end else begin
          status_r <= ffa_pkg::ST_NOSPACE;
        end
      end
    end
  end

  assign status = status_r;
  assign alloc_offset = goff_r;
  assign alloc_size = gsize_r;

  `include "fenced_first_fit_allocator_core_macros.svh"
  `FFA_ASSERT_IMPL(a_cnt, clk, rst_n, 1'b1, fcnt_r <= CW'(FE), "free count overflow")
  `FFA_ASSERT_IMPL(a_bump, clk, rst_n, cmd.bump_step, !$isunknown(need_r), "need unknown")
endmodule

/* sv/fenced_first_fit_allocator_core.sv */
// Flow: a return passes through the return state, then the result state.
// An allocate passes through these states in order:
// flush scan, insertion sort swaps, merge, fit scan with slot shift or bump, result state.
// One transaction at a time; busy stays high through the result state and the
// next start is taken in the cycle after it. The result shows for one cycle on out_valid; the
// receiver cannot stall. Synchronous active-low reset empties both lists, zeroes the bump pointer.
module fenced_first_fit_allocator_core #(
  parameter int FREE_ENTRIES = 16,
  parameter int PENDING_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_req_size,
  input  logic [3:0]  in_align_log2,
  input  logic [31:0] in_ret_offset,
  input  logic [63:0] in_fence_value,
  input  logic [63:0] in_completed_fence,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_offset,
  output logic [31:0] out_alloc_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  ffa_pkg::ctrl_t cmd;
  ffa_pkg::stat_t st;
  logic [31:0] capacity_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= 32'd4194304;
    else if (cfg_valid) capacity_r <= cfg_data;
  end

  ffa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .st(st), .cmd(cmd), .busy(busy)
  );

  ffa_dp #(.FE(FREE_ENTRIES), .PE(PENDING_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .capacity(capacity_r),
    .in_req_size(in_req_size), .in_align_log2(in_align_log2),
    .in_ret_offset(in_ret_offset), .in_fence_value(in_fence_value),
    .in_completed_fence(in_completed_fence), .st(st),
    .status(out_status), .alloc_offset(out_alloc_offset),
    .alloc_size(out_alloc_size)
  );

  assign out_valid = cmd.finish;
endmodule

/* tb/alloc_checker.sv */
`timescale 1ns / 100ps
module alloc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_req_size,
  input  logic [3:0]  in_align_log2,
  input  logic [31:0] in_ret_offset,
  input  logic [63:0] in_fence_value,
  input  logic [63:0] in_completed_fence,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_alloc_offset,
  input  logic [31:0] out_alloc_size,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          accepted,
  output int          cfg_writes,
  output int          outstanding,
  output int          fail_count,
  output int          n_grant,
  output int          n_nospace,
  output int          n_dropped
);
  localparam int NFREE = 16;
  localparam int NPEND = 16;
  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] size;
  } grant_t;

  grant_t      grant_q[$];
  logic [31:0] capacity;
  logic [31:0] free_off [NFREE];
  logic [31:0] free_sz [NFREE];
  int          free_cnt;
  logic [63:0] pend_fence [NPEND];
  logic [31:0] pend_off [NPEND];
  logic [31:0] pend_sz [NPEND];
  logic        pend_vld [NPEND];
  logic [63:0] bump;

  initial begin
    accepted = 0;
    cfg_writes = 0;
    outstanding = 0;
    fail_count = 0;
    n_grant = 0;
    n_nospace = 0;
    n_dropped = 0;
  end

  function automatic void remove_free(int idx);
    for (int k = idx; k + 1 < free_cnt; k++) begin
      free_off[k] = free_off[k + 1];
      free_sz[k] = free_sz[k + 1];
    end
    free_cnt--;
  endfunction

  function automatic void retire_fenced(logic [63:0] done);
    for (int p = 0; p < NPEND; p++) begin
      if (pend_vld[p] && pend_fence[p] <= done && free_cnt < NFREE) begin
        free_off[free_cnt] = pend_off[p];
        free_sz[free_cnt] = pend_sz[p];
        free_cnt++;
        pend_vld[p] = 1'b0;
      end
    end
  endfunction

  function automatic void sort_and_coalesce();
    logic [31:0] o, s;
    logic [63:0] end64, merged;
    int j, i;
    for (i = 1; i < free_cnt; i++) begin
      o = free_off[i];
      s = free_sz[i];
      j = i;
      // strict compare keeps equal offsets in their original order
      while (j > 0 && free_off[j - 1] > o) begin
        free_off[j] = free_off[j - 1];
        free_sz[j] = free_sz[j - 1];
        j--;
      end
      free_off[j] = o;
      free_sz[j] = s;
    end
    i = 0;
    while (i + 1 < free_cnt) begin
      end64 = {32'd0, free_off[i]} + {32'd0, free_sz[i]};
      merged = {32'd0, free_sz[i]} + {32'd0, free_sz[i + 1]};
      if (end64 == {32'd0, free_off[i + 1]} && merged <= MAX32) begin
        free_sz[i] = merged[31:0];
        remove_free(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic grant_t predict_grant(logic mode, logic [31:0] size, logic [3:0] lg,
                                           logic [31:0] roff, logic [63:0] fence,
                                           logic [63:0] done);
    grant_t g;
    logic [63:0] amask, need;
    bit hit;
    g.status = ffa_pkg::ST_OK;
    g.offset = '0;
    g.size = '0;
    hit = 0;
    if (mode) begin
      if (size != 0) begin
        g.status = ffa_pkg::ST_PENDFULL;
        for (int p = 0; p < NPEND; p++) begin
          if (!pend_vld[p]) begin
            pend_vld[p] = 1'b1;
            pend_fence[p] = fence;
            pend_off[p] = roff;
            pend_sz[p] = size;
            g.status = ffa_pkg::ST_OK;
            break;
          end
        end
      end
    end else begin
      amask = (64'd1 << lg) - 64'd1;
      need = ({32'd0, size} + amask) & ~amask;
      retire_fenced(done);
      sort_and_coalesce();
      if (need != 0 && need <= MAX32) begin
        for (int i = 0; i < free_cnt; i++) begin
          if ({32'd0, free_sz[i]} >= need) begin
            g.offset = free_off[i];
            if ({32'd0, free_sz[i]} == need) begin
              remove_free(i);
            end else begin
              free_sz[i] = free_sz[i] - need[31:0];
              free_off[i] = free_off[i] + need[31:0];
            end
            hit = 1;
            break;
          end
        end
        if (!hit && bump + need <= {32'd0, capacity}) begin
          g.offset = bump[31:0];
          bump = bump + need;
          hit = 1;
        end
      end
      if (hit) begin
        g.size = need[31:0];
      end else begin
        g.status = ffa_pkg::ST_NOSPACE;
        g.offset = '0;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      capacity = 32'd4194304;
      free_cnt = 0;
      bump = '0;
      for (int p = 0; p < NPEND; p++) pend_vld[p] = 1'b0;
      grant_q.delete();
    end else begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result status=%0d offset=%h size=%h", $realtime,
                     out_status, out_alloc_offset, out_alloc_size);
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status || out_alloc_offset !== want.offset ||
              out_alloc_size !== want.size) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp status=%0d offset=%h size=%h, got %0d %h %h",
                       $realtime, want.status, want.offset, want.size, out_status,
                       out_alloc_offset, out_alloc_size);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
        cfg_writes++;
      end
      if (start && !busy) begin
        want = predict_grant(in_mode, in_req_size, in_align_log2, in_ret_offset,
                             in_fence_value, in_completed_fence);
        grant_q = {grant_q, want};
        accepted++;
        if (want.status == ffa_pkg::ST_NOSPACE) n_nospace++;
        else if (want.status == ffa_pkg::ST_PENDFULL) n_dropped++;
        else if (!in_mode) n_grant++;
      end
      outstanding = grant_q.size();
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  typedef struct {
    logic [31:0] offset;
    logic [31:0] size;
  } region_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [31:0] in_req_size;
  logic [3:0]  in_align_log2;
  logic [31:0] in_ret_offset;
  logic [63:0] in_fence_value;
  logic [63:0] in_completed_fence;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_alloc_offset;
  logic [31:0] out_alloc_size;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int accepted, cfg_writes, outstanding, fail_count, n_grant, n_nospace, n_dropped;
  bit          gaps_on;
  region_t     live_q[$];
  logic [63:0] fence_ctr;
  logic [63:0] done_fence;

  fenced_first_fit_allocator_core dut (.*);

  alloc_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // remember live grants so returns can hand them back
  always @(posedge clk) begin
    if (rst_n && out_valid && out_status == ffa_pkg::ST_OK && out_alloc_size != 0)
      live_q = {live_q, region_t'{out_alloc_offset, out_alloc_size}};
  end

  task automatic send_item(logic mode, logic [31:0] size, logic [3:0] lg, logic [31:0] roff,
                           logic [63:0] fence, logic [63:0] done);
    int seen;
    seen = accepted;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 14) @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_req_size <= size;
    in_align_log2 <= lg;
    in_ret_offset <= roff;
    in_fence_value <= fence;
    in_completed_fence <= done;
    do @(negedge clk); while (accepted == seen);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    int seen;
    drain();
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_transaction();
    int r, k;
    logic [31:0] size;
    region_t reg_i;
    r = $urandom_range(99);
    if (r < 45 && live_q.size() != 0) begin
      k = $urandom_range(live_q.size() - 1);
      reg_i = live_q[k];
      live_q.delete(k);
      fence_ctr = fence_ctr + 64'($urandom_range(1, 3));
      send_item(1'b1, reg_i.size, 4'($urandom), reg_i.offset, fence_ctr,
                {$urandom, $urandom});
    end else if (r < 55) begin
      size = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      send_item(1'b1, size, 4'($urandom), $urandom, {$urandom, $urandom},
                {$urandom, $urandom});
    end else begin
      case ($urandom_range(19))
        0: size = 32'd0;
        1: size = $urandom;
        default: size = $urandom_range(1, 2048);
      endcase
      // let the completed fence trail the issued one, sometimes jump to a random value
      if ($urandom_range(15) == 0) done_fence = {$urandom, $urandom};
      else done_fence = fence_ctr - 64'($urandom_range(0, 4));
      send_item(1'b0, size, ($urandom_range(9) == 0) ? 4'($urandom_range(7, 15))
                : 4'($urandom_range(0, 6)), $urandom, {$urandom, $urandom}, done_fence);
    end
  endtask

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [31:0] caps [4];
    caps = '{32'd4096, 32'hFFFF_FFFF, 32'd1, 32'd8000000};
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_req_size = '0;
    in_align_log2 = '0;
    in_ret_offset = '0;
    in_fence_value = '0;
    in_completed_fence = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    gaps_on = 1'b1;
    fence_ctr = 64'd100;
    done_fence = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: size and alignment extremes, fences, full pending and free lists
    send_item(1'b0, 32'd0, 4'd0, '0, '0, '0);
    send_item(1'b0, 32'hFFFF_FFFF, 4'd12, '0, '0, '0);
    send_item(1'b0, 32'd100, 4'd4, '0, '0, '0);
    send_item(1'b0, 32'd1, 4'd15, '0, '0, '0);
    send_item(1'b0, 32'd5000000, 4'd0, '0, '0, '0);
    send_item(1'b1, 32'd0, 4'd0, 32'd64, 64'd1, '0);
    send_item(1'b1, 32'd112, 4'd0, 32'd0, 64'd5, '0);
    send_item(1'b0, 32'd16, 4'd0, '0, '0, 64'd4);
    send_item(1'b0, 32'd16, 4'd0, '0, '0, 64'd5);
    send_item(1'b1, 32'h8000_0000, 4'd0, 32'h8000_0000, 64'd6, '0);
    send_item(1'b1, 32'h20, 4'd0, 32'hFFFF_FFF0, 64'd6, '0);
    send_item(1'b0, 32'h7FFF_FFF0, 4'd4, '0, '0, 64'd6);
    for (int i = 0; i < 17; i++)
      send_item(1'b1, 32'd1, 4'd0, 32'h0010_0000 + 32'(i * 4), 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(1'b0, 32'd1, 4'd0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 32'd8, 4'd3, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);

    for (int ph = 0; ph < 5; ph++) begin
      gaps_on = (ph != 2);
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 75) drain();
        random_transaction();
      end
      if (ph < 4) write_capacity(caps[ph]);
    end

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d transactions over five capacity settings (%0d register writes).",
             accepted, cfg_writes);
    $display("Grants %0d, no-space %0d, dropped returns %0d.", n_grant, n_nospace, n_dropped);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
